// File: design/brr_pkg.sv
// shared types, widths and filter coefficients of the block-stream sample decoder
// no dependencies
package brr_pkg;

  localparam int BYTE_W   = 8;
  localparam int NIB_W    = 4;
  localparam int POS_W    = 4;
  localparam int SHIFT_W  = 4;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 8;
  localparam int ACC_W    = 24;
  localparam int FRAC_W   = 6;
  localparam int QUOT_W   = ACC_W - FRAC_W;

  localparam logic [POS_W-1:0]   POS_HEADER    = 4'd0;
  localparam logic [POS_W-1:0]   POS_FIRST     = 4'd1;
  localparam logic [POS_W-1:0]   POS_LAST      = 4'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX_LIN = 4'd12;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX  = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN  = -16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] RAW_NEG_BIG = -16'sd2048;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_ONE   = 2'd1,
    FLT_TWO   = 2'd2,
    FLT_THREE = 2'd3
  } filter_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    filter_t            filter;
  } hdr_t;

  function automatic logic signed [COEF_W-1:0] coef_newer(input filter_t f);
    logic signed [COEF_W-1:0] c;
    case (f)
      FLT_NONE:  c = 8'sd0;
      FLT_ONE:   c = 8'sd60;
      FLT_TWO:   c = 8'sd122;
      FLT_THREE: c = 8'sd115;
      default:   c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_older(input filter_t f);
    logic signed [COEF_W-1:0] c;
    case (f)
      FLT_NONE:  c = 8'sd0;
      FLT_ONE:   c = 8'sd0;
      FLT_TWO:   c = -8'sd60;
      FLT_THREE: c = -8'sd52;
      default:   c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

// File: design/brr_sample_calc.sv
// one nibble to one saturated sample: scale, two-tap prediction, truncate, clip
// depends on brr_pkg
module brr_sample_calc
  import brr_pkg::*;
(
  input  logic [NIB_W-1:0]           nibble,
  input  hdr_t                       hdr,
  input  logic signed [SAMPLE_W-1:0] hist_newer,
  input  logic signed [SAMPLE_W-1:0] hist_older,
  output logic signed [SAMPLE_W-1:0] sample
);

  logic signed [NIB_W-1:0]    nib_s;
  logic signed [SAMPLE_W-1:0] nib_ext;
  logic signed [SAMPLE_W-1:0] raw;
  logic signed [ACC_W-1:0]    raw_scaled;
  logic signed [ACC_W-1:0]    prod_newer;
  logic signed [ACC_W-1:0]    prod_older;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_adj;
  logic signed [QUOT_W-1:0]   quot;

  assign nib_s   = signed'(nibble);
  assign nib_ext = SAMPLE_W'(nib_s);

  always_comb begin
    if (hdr.shift == '0) begin
      raw = nib_ext >>> 1;
    end else if (hdr.shift <= SHIFT_MAX_LIN) begin
      raw = nib_ext <<< (hdr.shift - 1'b1);
    end else begin
      raw = nib_s[NIB_W-1] ? RAW_NEG_BIG : '0;
    end
  end

  assign raw_scaled = ACC_W'(raw) <<< FRAC_W;
  assign prod_newer = ACC_W'(coef_newer(hdr.filter)) * ACC_W'(hist_newer);
  assign prod_older = ACC_W'(coef_older(hdr.filter)) * ACC_W'(hist_older);
  assign acc        = raw_scaled + prod_newer + prod_older;

  // truncate toward zero
  assign acc_adj = acc[ACC_W-1] ? acc + ACC_W'((1 << FRAC_W) - 1) : acc;
  assign quot    = QUOT_W'(acc_adj >>> FRAC_W);

  always_comb begin
    if (quot > QUOT_W'(SAMPLE_MAX)) begin
      sample = SAMPLE_MAX;
    end else if (quot < QUOT_W'(SAMPLE_MIN)) begin
      sample = SAMPLE_MIN;
    end else begin
      sample = quot[SAMPLE_W-1:0];
    end
  end

endmodule

// File: design/brr_adpcm_block_decoder_core.sv
// top level of the block-stream adpcm decoder: byte stage, history, result register
// depends on brr_pkg and brr_sample_calc
//
// Takes one stream byte per input transfer and gives 16-bit samples on the result
// channel, two per data byte (high nibble first, pair_last on the second) and none for
// a header byte. A byte waits in one stage register; a header is used up there without
// waiting for the result side, a data byte one nibble per cycle while the result side
// is not stalled, since the second sample needs the first in the history registers. A
// new byte is taken in the same cycle as the staged one is used up. A sample appears on
// the result port the cycle after its nibble is worked; input ready depends
// combinationally on out_ready. chain_start forces the byte to be a header and clears
// the history.
module brr_adpcm_block_decoder_core
  import brr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [BYTE_W-1:0]          in_brr_byte,
  input  logic                       in_chain_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_pcm_sample,
  output logic                       out_block_loop,
  output logic                       out_block_end,
  output logic                       out_pair_last
);

  logic                       stg_vld_r, stg_vld_nxt;
  logic [BYTE_W-1:0]          stg_byte_r;
  logic                       stg_chain_r;
  logic                       phase_r, phase_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  hdr_t                       hdr_r, hdr_nxt;
  logic                       loop_r, loop_nxt;
  logic                       end_r, end_nxt;
  logic signed [SAMPLE_W-1:0] hist_newer_r, hist_newer_nxt;
  logic signed [SAMPLE_W-1:0] hist_older_r, hist_older_nxt;
  logic                       out_vld_r, out_vld_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_loop_r;
  logic                       out_end_r;
  logic                       out_last_r;

  logic                       stg_hdr;
  logic                       stg_adv;
  logic                       stg_done;
  logic                       in_xfer;
  logic [NIB_W-1:0]           cur_nib;
  logic signed [SAMPLE_W-1:0] cur_sample;

  assign stg_hdr  = stg_chain_r || (pos_r == POS_HEADER) || (pos_r > POS_LAST);
  assign stg_adv  = stg_vld_r && (stg_hdr || !out_vld_r || out_ready);
  assign stg_done = stg_adv && (stg_hdr || phase_r);
  assign in_ready = !stg_vld_r || stg_done;
  assign in_xfer  = in_valid && in_ready;
  assign cur_nib  = phase_r ? stg_byte_r[NIB_W-1:0] : stg_byte_r[BYTE_W-1:NIB_W];

  brr_sample_calc u_calc (
    .nibble     (cur_nib),
    .hdr        (hdr_r),
    .hist_newer (hist_newer_r),
    .hist_older (hist_older_r),
    .sample     (cur_sample)
  );

  always_comb begin
    stg_vld_nxt    = stg_vld_r;
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    hdr_nxt        = hdr_r;
    loop_nxt       = loop_r;
    end_nxt        = end_r;
    hist_newer_nxt = hist_newer_r;
    hist_older_nxt = hist_older_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    if (stg_adv) begin
      if (stg_hdr) begin
        hdr_nxt.shift  = stg_byte_r[7:4];
        hdr_nxt.filter = filter_t'(stg_byte_r[3:2]);
        loop_nxt       = stg_byte_r[1];
        end_nxt        = stg_byte_r[0];
        pos_nxt        = POS_FIRST;
        phase_nxt      = 1'b0;
        if (stg_chain_r) begin
          hist_newer_nxt = '0;
          hist_older_nxt = '0;
        end
      end else begin
        hist_older_nxt = hist_newer_r;
        hist_newer_nxt = cur_sample;
        out_vld_nxt    = 1'b1;
        phase_nxt      = !phase_r;
        if (phase_r) begin
          pos_nxt = (pos_r >= POS_LAST) ? POS_HEADER : pos_r + 1'b1;
        end
      end
    end
    if (stg_done) begin
      stg_vld_nxt = 1'b0;
    end
    if (in_xfer) begin
      stg_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r    <= 1'b0;
      phase_r      <= 1'b0;
      pos_r        <= POS_HEADER;
      hdr_r        <= '0;
      loop_r       <= 1'b0;
      end_r        <= 1'b0;
      hist_newer_r <= '0;
      hist_older_r <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      stg_vld_r    <= stg_vld_nxt;
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      hdr_r        <= hdr_nxt;
      loop_r       <= loop_nxt;
      end_r        <= end_nxt;
      hist_newer_r <= hist_newer_nxt;
      hist_older_r <= hist_older_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_byte_r  <= in_brr_byte;
      stg_chain_r <= in_chain_start;
    end
    if (stg_adv && !stg_hdr) begin
      out_sample_r <= cur_sample;
      out_loop_r   <= loop_r;
      out_end_r    <= end_r;
      out_last_r   <= phase_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_pcm_sample = out_sample_r;
  assign out_block_loop = out_loop_r;
  assign out_block_end  = out_end_r;
  assign out_pair_last  = out_last_r;

`ifndef SYNTHESIS
  // second nibble only while a data byte sits in the stage
  a_phase_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (stg_vld_r && !stg_hdr))
    else $error("low nibble phase without a data byte in the stage");

  // low nibble finished means a pair-closing sample on the result port
  a_pair_close: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_adv && !stg_hdr && phase_r) |=> (out_valid && out_pair_last))
    else $error("low nibble sample not presented with pair_last");

  // a header never produces a result
  a_hdr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_adv && stg_hdr && !(out_valid && !out_ready)) |=> !out_valid)
    else $error("header byte produced a sample");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position out of range");
`endif

endmodule
